// ----- rtl/core/lae_pkg.sv -----
// Shared constants, codes and command type of the life automaton engine.
package lae_pkg;

   // Grid size; cells beyond the address range still evolve.
   localparam int GRID_COLS = 64;
   localparam int GRID_ROWS = 64;

   // Transaction field widths.
   localparam int ACTION_W = 2;
   localparam int REQ_COL_W = 6;
   localparam int REQ_ROW_W = 6;
   localparam int GEN_W = 32;

   // Derived widths for row and column indexing and range checks.
   localparam int ROW_IDX_W = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
   localparam int COL_IDX_W = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;
   localparam int ROW_LIM_W = $clog2(GRID_ROWS + 1);
   localparam int COL_LIM_W = $clog2(GRID_COLS + 1);
   localparam int ROW_CMP_W = (ROW_LIM_W > REQ_ROW_W) ? ROW_LIM_W : REQ_ROW_W;
   localparam int COL_CMP_W = (COL_LIM_W > REQ_COL_W) ? COL_LIM_W : REQ_COL_W;
   localparam int SWEEP_CNT_W = $clog2(GRID_ROWS + 3);

   // Rule B3/S23.
   localparam int BIRTH_COUNT = 3;
   localparam int STAY_COUNT = 2;

   // Action codes.
   localparam logic [ACTION_W-1:0] ACT_ADVANCE = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_TOGGLE = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd2;
   localparam logic [ACTION_W-1:0] ACT_READ = 2'd3;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic                 capture_req;
      logic                 rd_en;
      logic                 rd_sweep;
      logic [ROW_IDX_W-1:0] rd_row;
      logic                 wr_sweep;
      logic                 wr_toggle;
      logic [ROW_IDX_W-1:0] wr_row;
      logic                 win_clear;
      logic                 win_shift;
      logic                 shift_zero;
      logic                 grid_clear;
      logic                 gen_inc;
      logic                 load_rsp;
   } lae_cmd_type;

endpackage

// ----- rtl/core/lae_req_if.sv -----
// Request channel interface: action and cell coordinate.
interface lae_req_if;
   import lae_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [ACTION_W-1:0]  action;
   logic [REQ_COL_W-1:0] col;
   logic [REQ_ROW_W-1:0] row;

   modport source (output valid, output action, output col, output row, input ready);
   modport sink (input valid, input action, input col, input row, output ready);

endinterface

// ----- rtl/core/lae_rsp_if.sv -----
// Response channel interface: addressed cell state and generation count.
interface lae_rsp_if;
   import lae_pkg::*;

   logic             valid;
   logic             ready;
   logic             alive;
   logic [GEN_W-1:0] generation;

   modport source (output valid, output alive, output generation, input ready);
   modport sink (input valid, input alive, input generation, output ready);

endinterface

// ----- rtl/core/lae_ctrl.sv -----
// Controller state machine sequencing each transaction and the generation sweep.
module lae_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic [lae_pkg::ACTION_W-1:0] req_action,
   output logic                         req_ready,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output lae_pkg::lae_cmd_type         cmd
);
   import lae_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_SWEEP  = 3'd1;
   localparam logic [2:0] S_TOG_RD = 3'd2;
   localparam logic [2:0] S_TOG_WR = 3'd3;
   localparam logic [2:0] S_CLEAR  = 3'd4;
   localparam logic [2:0] S_FETCH  = 3'd5;
   localparam logic [2:0] S_RESP   = 3'd6;

   // Sweep timing: a row read lands in the window through the read data register, and
   // the window is complete for a row once the row below it has landed as well.
   localparam logic [SWEEP_CNT_W-1:0] FIRST_SHIFT = SWEEP_CNT_W'(1);
   localparam logic [SWEEP_CNT_W-1:0] FIRST_WRITE = SWEEP_CNT_W'(3);
   localparam logic [SWEEP_CNT_W-1:0] ROWS_CNT = SWEEP_CNT_W'(GRID_ROWS);
   localparam logic [SWEEP_CNT_W-1:0] LAST_CNT = SWEEP_CNT_W'(GRID_ROWS + 2);

   logic [2:0]             state_ff, state_in;
   logic [SWEEP_CNT_W-1:0] cnt_ff, cnt_in;
   logic [SWEEP_CNT_W-1:0] wr_cnt;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   accept;
   logic                   rsp_free;

   assign accept = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_free = !rsp_valid_ff || rsp_ready;
   assign wr_cnt = cnt_ff - FIRST_WRITE;

   // Next state, sweep count and datapath commands.
   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      cmd = '0;
      cmd.rd_row = cnt_ff[ROW_IDX_W-1:0];
      cmd.wr_row = wr_cnt[ROW_IDX_W-1:0];
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.capture_req = 1'b1;
               cnt_in = '0;
               unique case (req_action)
                  ACT_ADVANCE: state_in = S_SWEEP;
                  ACT_TOGGLE:  state_in = S_TOG_RD;
                  ACT_CLEAR:   state_in = S_CLEAR;
                  ACT_READ:    state_in = S_FETCH;
               endcase
            end
         end
         S_SWEEP: begin
            cmd.win_clear = (cnt_ff == '0);
            cmd.rd_en = (cnt_ff < ROWS_CNT);
            cmd.rd_sweep = 1'b1;
            cmd.win_shift = (cnt_ff >= FIRST_SHIFT) && (cnt_ff <= ROWS_CNT);
            cmd.win_shift = cmd.win_shift || (cnt_ff == ROWS_CNT + FIRST_SHIFT);
            cmd.shift_zero = (cnt_ff > ROWS_CNT);
            cmd.wr_sweep = (cnt_ff >= FIRST_WRITE);
            if (cnt_ff == LAST_CNT) begin
               cmd.gen_inc = 1'b1;
               state_in = S_FETCH;
            end else begin
               cnt_in = cnt_ff + SWEEP_CNT_W'(1);
            end
         end
         S_TOG_RD: begin
            cmd.rd_en = 1'b1;
            state_in = S_TOG_WR;
         end
         S_TOG_WR: begin
            cmd.wr_toggle = 1'b1;
            state_in = S_FETCH;
         end
         S_CLEAR: begin
            cmd.grid_clear = 1'b1;
            state_in = S_FETCH;
         end
         S_FETCH: begin
            cmd.rd_en = 1'b1;
            state_in = S_RESP;
         end
         S_RESP: begin
            if (rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Response valid flag: set when a result is loaded, dropped when taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ----- rtl/core/lae_dpath.sv -----
// Datapath: row memory, three-row window, rule lanes, counter and result register.
module lae_dpath (
   input  logic                          clock,
   input  logic                          reset,
   input  lae_pkg::lae_cmd_type          cmd,
   input  logic [lae_pkg::REQ_COL_W-1:0] req_col,
   input  logic [lae_pkg::REQ_ROW_W-1:0] req_row,
   output logic                          rsp_alive,
   output logic [lae_pkg::GEN_W-1:0]     rsp_generation
);
   import lae_pkg::*;

   localparam int NBR_CNT_W = 4;

   // Captured coordinate; the action itself is decoded by the controller.
   logic [REQ_COL_W-1:0] col_ff;
   logic [REQ_ROW_W-1:0] row_ff;
   logic [ROW_CMP_W-1:0] row_ext;
   logic [COL_CMP_W-1:0] col_ext;
   logic [ROW_IDX_W-1:0] row_idx;
   logic [COL_IDX_W-1:0] col_idx;
   logic                 on_grid;

   // Grid store, one word per row, with a valid flag per row.
   logic [GRID_COLS-1:0] grid_mem [GRID_ROWS];
   logic [GRID_ROWS-1:0] row_valid_ff;
   logic [GRID_COLS-1:0] rd_data_ff;
   logic                 rd_ok_ff;
   logic [GRID_COLS-1:0] rd_row_val;
   logic [ROW_IDX_W-1:0] rd_addr;
   logic [ROW_IDX_W-1:0] wr_addr;
   logic [GRID_COLS-1:0] wr_data;
   logic                 wr_en;

   // Window of old rows around the row being computed.
   logic [GRID_COLS-1:0] above_ff, cur_ff, below_ff;
   logic [GRID_COLS+1:0] pad_above, pad_cur, pad_below;
   logic [GRID_COLS-1:0] next_row;

   logic [GEN_W-1:0] gen_ff;
   logic             alive_ff;
   logic [GEN_W-1:0] gen_rsp_ff;

   // New state of one cell from its own state and its eight neighbours.
   function automatic logic life_rule(input logic self, input logic [7:0] nbrs);
      logic [NBR_CNT_W-1:0] n;
      n = '0;
      for (int k = 0; k < 8; k++) begin
         n = n + NBR_CNT_W'(nbrs[k]);
      end
      if (self) begin
         return (n == NBR_CNT_W'(STAY_COUNT)) || (n == NBR_CNT_W'(BIRTH_COUNT));
      end
      return (n == NBR_CNT_W'(BIRTH_COUNT));
   endfunction

   always_ff @(posedge clock) begin
      if (cmd.capture_req) begin
         col_ff <= req_col;
         row_ff <= req_row;
      end
   end

   // Address decode and range check of the captured coordinate.
   assign row_ext = ROW_CMP_W'(row_ff);
   assign col_ext = COL_CMP_W'(col_ff);
   assign row_idx = row_ext[ROW_IDX_W-1:0];
   assign col_idx = col_ext[COL_IDX_W-1:0];
   assign on_grid = (row_ext < ROW_CMP_W'(GRID_ROWS)) && (col_ext < COL_CMP_W'(GRID_COLS));

   // A row that was never written since reset or clear reads as dead.
   assign rd_row_val = rd_ok_ff ? rd_data_ff : '0;

   // Next row: one rule lane per column, edges padded with dead cells.
   assign pad_above = {1'b0, above_ff, 1'b0};
   assign pad_cur = {1'b0, cur_ff, 1'b0};
   assign pad_below = {1'b0, below_ff, 1'b0};

   always_comb begin
      for (int c = 0; c < GRID_COLS; c++) begin
         next_row[c] = life_rule(pad_cur[c+1],
                                 {pad_above[c], pad_above[c+1], pad_above[c+2],
                                  pad_cur[c], pad_cur[c+2],
                                  pad_below[c], pad_below[c+1], pad_below[c+2]});
      end
   end

   // Memory port selection.
   assign rd_addr = cmd.rd_sweep ? cmd.rd_row : row_idx;
   assign wr_addr = cmd.wr_sweep ? cmd.wr_row : row_idx;
   assign wr_data = cmd.wr_sweep ? next_row
                                 : (rd_row_val ^ (GRID_COLS'(1) << col_idx));
   assign wr_en = cmd.wr_sweep || (cmd.wr_toggle && on_grid);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         grid_mem[wr_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= grid_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
         rd_ok_ff <= 1'b0;
      end else begin
         if (cmd.grid_clear) begin
            row_valid_ff <= '0;
         end else if (wr_en) begin
            row_valid_ff[wr_addr] <= 1'b1;
         end
         if (cmd.rd_en) begin
            rd_ok_ff <= row_valid_ff[rd_addr];
         end
      end
   end

   // Row window shift during a sweep.
   always_ff @(posedge clock) begin
      if (cmd.win_clear) begin
         above_ff <= '0;
         cur_ff <= '0;
         below_ff <= '0;
      end else if (cmd.win_shift) begin
         above_ff <= cur_ff;
         cur_ff <= below_ff;
         below_ff <= cmd.shift_zero ? '0 : rd_row_val;
      end
   end

   // Generation counter, wrapping at its width.
   always_ff @(posedge clock) begin
      if (reset) begin
         gen_ff <= '0;
      end else if (cmd.grid_clear) begin
         gen_ff <= '0;
      end else if (cmd.gen_inc) begin
         gen_ff <= gen_ff + GEN_W'(1);
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         alive_ff <= on_grid && rd_row_val[col_idx];
         gen_rsp_ff <= gen_ff;
      end
   end

   assign rsp_alive = alive_ff;
   assign rsp_generation = gen_rsp_ff;

endmodule

// ----- rtl/core/life_automaton_engine_unit.sv -----
// Top level of the life automaton engine: controller plus datapath.
//
//  Channel   Direction  Content
//  req_ch    in         action, col, row
//  rsp_ch    out        alive, generation
//
// One transaction is taken at a time; req_ch is ready only while idle.
// An advance sweep reads one row per cycle through the single memory read port;
// toggle reads and rewrites its row, and every action ends by fetching its row.
// Reset is synchronous and kills the grid at once through per-row valid flags.
// The result waits in an output register while the next transaction is accepted;
// a stalled rsp_ch holds the engine only at its end.
module life_automaton_engine_unit (
   input  logic       clock,
   input  logic       reset,
   lae_req_if.sink    req_ch,
   lae_rsp_if.source  rsp_ch
);
   import lae_pkg::*;

   lae_cmd_type cmd;

   lae_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_ch.valid),
      .req_action (req_ch.action),
      .req_ready  (req_ch.ready),
      .rsp_valid  (rsp_ch.valid),
      .rsp_ready  (rsp_ch.ready),
      .cmd        (cmd)
   );

   lae_dpath u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .req_col        (req_ch.col),
      .req_row        (req_ch.row),
      .rsp_alive      (rsp_ch.alive),
      .rsp_generation (rsp_ch.generation)
   );

endmodule

// ----- sim/life_automaton_engine_unit_test.sv -----
// Self-checking testbench for the life automaton engine: action, cell and generation checks.
`timescale 1ns / 1ps

module life_automaton_engine_unit_test;
   import lae_pkg::*;

   // One expected result: the addressed cell and the generation count after the action.
   typedef struct packed {
      logic             alive;
      logic [GEN_W-1:0] generation;
   } cell_report_type;

   logic clock;
   logic reset;

   lae_req_if req_ch ();
   lae_rsp_if rsp_ch ();

   life_automaton_engine_unit i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // Predicted state of the engine: cell grid indexed by row then column.
   bit               life_grid [0:GRID_ROWS-1][0:GRID_COLS-1];
   logic [GEN_W-1:0] gen_total;

   cell_report_type reports_due [$];
   int              error_count;
   int              requests_accepted;
   bit              steady_flow;

   // Free-running clock, 20 ns period.
   initial clock = 1'b0;
   always #10 clock = ~clock;

   // Cells beyond the edges count as dead.
   function automatic bit cell_at(input int r, input int c);
      if (r < 0 || c < 0 || r >= GRID_ROWS || c >= GRID_COLS) begin
         return 1'b0;
      end
      return life_grid[r][c];
   endfunction

   // One generation of rule B3/S23, every cell taken from the old generation.
   function automatic void advance_life();
      bit          next_cells [0:GRID_ROWS-1][0:GRID_COLS-1];
      int unsigned n;
      for (int r = 0; r < GRID_ROWS; r++) begin
         for (int c = 0; c < GRID_COLS; c++) begin
            n = 0;
            for (int dr = -1; dr <= 1; dr++) begin
               for (int dc = -1; dc <= 1; dc++) begin
                  if ((dr != 0 || dc != 0) && cell_at(r + dr, c + dc)) begin
                     n++;
                  end
               end
            end
            if (life_grid[r][c]) begin
               next_cells[r][c] = (n == STAY_COUNT) || (n == BIRTH_COUNT);
            end else begin
               next_cells[r][c] = (n == BIRTH_COUNT);
            end
         end
      end
      life_grid = next_cells;
      gen_total = gen_total + 1'b1;
   endfunction

   // Applies one action to the predicted state and works out the result it yields.
   function automatic cell_report_type predict_report(input logic [ACTION_W-1:0]  action,
                                                      input logic [REQ_COL_W-1:0] col,
                                                      input logic [REQ_ROW_W-1:0] row);
      cell_report_type report;
      bit              on_grid;
      on_grid = (int'(col) < GRID_COLS) && (int'(row) < GRID_ROWS);
      case (action)
         ACT_ADVANCE: begin
            advance_life();
         end
         ACT_TOGGLE: begin
            if (on_grid) begin
               life_grid[row][col] = ~life_grid[row][col];
            end
         end
         ACT_CLEAR: begin
            for (int r = 0; r < GRID_ROWS; r++) begin
               for (int c = 0; c < GRID_COLS; c++) begin
                  life_grid[r][c] = 1'b0;
               end
            end
            gen_total = '0;
         end
         default: begin
         end
      endcase
      report.alive = on_grid ? life_grid[row][col] : 1'b0;
      report.generation = gen_total;
      return report;
   endfunction

   // Sends one request after a random gap, or none in steady flow, and records its expected result on acceptance.
   task automatic issue_request(input logic [ACTION_W-1:0]  action,
                                input logic [REQ_COL_W-1:0] col,
                                input logic [REQ_ROW_W-1:0] row);
      int gap;
      gap = steady_flow ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid  <= 1'b1;
      req_ch.action <= action;
      req_ch.col    <= col;
      req_ch.row    <= row;
      do @(posedge clock); while (!req_ch.ready);
      reports_due.push_back(predict_report(action, col, row));
      requests_accepted++;
   endtask

   // A coordinate inside a six-cell window; the window may wrap past the last column or row to zero.
   function automatic logic [5:0] near(input logic [5:0] base);
      return 6'(base + $urandom_range(0, 5));
   endfunction

   // Result side: random stalls before each transaction, with stall-free stretches.
   initial begin
      int stall;
      rsp_ch.ready <= 1'b0;
      @(negedge reset);
      @(posedge clock);
      forever begin
         stall = steady_flow ? 0 : $urandom_range(0, 3);
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_ch.valid && rsp_ch.ready));
      end
   end

   // Compares each accepted result with the oldest expectation.
   always @(posedge clock) begin
      cell_report_type due;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (reports_due.size() == 0) begin
            $error("unexpected result: alive %0d, generation %0d",
                   rsp_ch.alive, rsp_ch.generation);
            error_count++;
         end else begin
            due = reports_due.pop_front();
            if (rsp_ch.alive !== due.alive) begin
               $error("alive mismatch: expected %0d, actual %0d", due.alive, rsp_ch.alive);
               error_count++;
            end
            if (rsp_ch.generation !== due.generation) begin
               $error("generation mismatch: expected %0d, actual %0d",
                      due.generation, rsp_ch.generation);
               error_count++;
            end
         end
      end
   end

   // The state straight after reset is an empty grid at generation zero.
   task automatic test_reset_state();
      issue_request(ACT_READ, 6'd0, 6'd0);
      issue_request(ACT_READ, 6'd63, 6'd63);
   endtask

   // Toggles at all four corners, and a second toggle that kills a cell again.
   task automatic test_toggle_corners();
      issue_request(ACT_TOGGLE, 6'd0, 6'd0);
      issue_request(ACT_TOGGLE, 6'd63, 6'd63);
      issue_request(ACT_TOGGLE, 6'd0, 6'd63);
      issue_request(ACT_TOGGLE, 6'd63, 6'd0);
      issue_request(ACT_TOGGLE, 6'd63, 6'd63);
      issue_request(ACT_READ, 6'd63, 6'd63);
   endtask

   // A blinker against the left edge: no wrap may wake the far column.
   task automatic test_edge_blinker();
      issue_request(ACT_CLEAR, 6'd0, 6'd0);
      issue_request(ACT_TOGGLE, 6'd0, 6'd10);
      issue_request(ACT_TOGGLE, 6'd0, 6'd11);
      issue_request(ACT_TOGGLE, 6'd0, 6'd12);
      issue_request(ACT_ADVANCE, 6'd1, 6'd11);
      issue_request(ACT_READ, 6'd63, 6'd11);
      issue_request(ACT_ADVANCE, 6'd0, 6'd12);
   endtask

   // Birth from three neighbours, then survival of the resulting block.
   task automatic test_birth_and_survival();
      issue_request(ACT_CLEAR, 6'd31, 6'd31);
      issue_request(ACT_TOGGLE, 6'd30, 6'd30);
      issue_request(ACT_TOGGLE, 6'd31, 6'd30);
      issue_request(ACT_TOGGLE, 6'd30, 6'd31);
      issue_request(ACT_ADVANCE, 6'd31, 6'd31);
      issue_request(ACT_ADVANCE, 6'd30, 6'd30);
   endtask

   // Random colonies seeded in small windows and evolved, mixed with random noise.
   task automatic test_random_evolution();
      int         last_request;
      logic [5:0] base_col;
      logic [5:0] base_row;
      int         seeds;
      int         steps;
      last_request = requests_accepted + 110;
      while (requests_accepted < last_request) begin
         steady_flow = ($urandom_range(0, 3) == 0);
         base_col = $urandom_range(0, 1) ? 6'($urandom_range(0, 63))
                                         : ($urandom_range(0, 1) ? 6'd0 : 6'd59);
         base_row = $urandom_range(0, 1) ? 6'($urandom_range(0, 63))
                                         : ($urandom_range(0, 1) ? 6'd0 : 6'd59);
         if ($urandom_range(0, 3) == 0) begin
            issue_request(ACT_CLEAR, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)));
         end
         seeds = $urandom_range(5, 12);
         repeat (seeds) issue_request(ACT_TOGGLE, near(base_col), near(base_row));
         steps = $urandom_range(2, 5);
         repeat (steps) begin
            issue_request(ACT_ADVANCE, near(base_col), near(base_row));
            if ($urandom_range(0, 1) == 0) begin
               issue_request(ACT_READ, near(base_col), near(base_row));
            end
         end
         // Noise: any action anywhere on the grid.
         repeat ($urandom_range(0, 2)) begin
            issue_request(ACTION_W'($urandom_range(0, 3)), 6'($urandom_range(0, 63)),
                          6'($urandom_range(0, 63)));
         end
      end
      steady_flow = 1'b0;
   endtask

   // Reset, the directed tests, the random test and the final verdict.
   initial begin
      reset         <= 1'b1;
      req_ch.valid  <= 1'b0;
      req_ch.action <= ACT_READ;
      req_ch.col    <= '0;
      req_ch.row    <= '0;
      error_count = 0;
      requests_accepted = 0;
      steady_flow = 1'b0;
      gen_total = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_state();
      test_toggle_corners();
      test_edge_blinker();
      test_birth_and_survival();
      test_random_evolution();
      req_ch.valid <= 1'b0;

      while (reports_due.size() != 0) @(posedge clock);
      repeat (GRID_ROWS + 16) @(posedge clock);
      if (error_count == 0 && reports_due.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // Watchdog: a hung handshake ends the run.
   initial begin
      #2_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule

// ----- life_automaton_engine_unit.f -----
rtl/core/lae_pkg.sv
rtl/core/lae_req_if.sv
rtl/core/lae_rsp_if.sv
rtl/core/lae_ctrl.sv
rtl/core/lae_dpath.sv
rtl/core/life_automaton_engine_unit.sv
sim/life_automaton_engine_unit_test.sv
